FILE: design/gdiv_pkg.sv
package gdiv_pkg;

   // Transform length limit and CORDIC depth defaults
   localparam int MAX_BINS     = 8192;
   localparam int CORDIC_STEPS = 24;

   // Datapath widths
   localparam int CW = 34;   // CORDIC x, y, z
   localparam int MW = 48;   // denominator magnitude
   localparam int QW = 32;   // quotient bits

   localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;
   localparam logic signed [CW-1:0] ONE_Q30      = 34'sd1073741824;

   localparam logic [31:0] PHASE_STEP_RESET = 32'd163591000;
   localparam logic [13:0] BIN_COUNT_RESET  = 14'd8192;

   typedef enum logic [0:0] {
      CSR_PHASE_STEP = 1'b0,
      CSR_BIN_COUNT  = 1'b1
   } csr_index_type;

   // Arctangent of 2^-i in 32-bit turns
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic [12:0]        bin_index;
      logic signed [31:0] spec_re;
      logic signed [31:0] spec_im;
   } req_type;

   typedef struct packed {
      logic [12:0]        out_index;
      logic signed [31:0] out_re;
      logic signed [31:0] out_im;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        zero_bin;
      logic [12:0] index;
   } meta_type;

   typedef struct packed {
      meta_type           meta;
      logic signed [31:0] re;
      logic signed [31:0] im;
   } sample_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_type;

   typedef struct packed {
      meta_type           meta;
      logic signed [63:0] nre;
      logic signed [63:0] nim;
      logic [MW-1:0]      m;
   } num_type;

   typedef struct packed {
      logic [MW-1:0] rem;
      logic [31:0]   low;
      logic [QW-1:0] q;
      logic          neg;
      logic          nz;
      logic          big;
   } div_lane_type;

   typedef struct packed {
      meta_type      meta;
      logic [MW-1:0] m;
      logic          zero_m;
      div_lane_type  lre;
      div_lane_type  lim;
   } div_stage_type;

endpackage

FILE: design/spectral_ghost_operator_divide.sv
// Divides one spectrum bin per clock by the receiver ghost operator 1 - exp(-i*theta).
// A request is taken on any cycle with start high and busy low; busy is high only
// during reset. Every request yields one result on rsp_valid after it passes through two
// phase stages, one CORDIC stage per iteration, three stages for the operator, its
// products and the numerators, and a 32-stage restoring divider with setup and
// output stages. The result is shown for one cycle only and cannot be held off.
// phase_step and bin_count are sampled at the head of the pipeline; write them only
// while no request is in flight.
module spectral_ghost_operator_divide #(
   parameter int CORDIC_STEPS = gdiv_pkg::CORDIC_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gdiv_pkg::req_type  req_data,
   output logic               rsp_valid,
   output gdiv_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int LATENCY = CORDIC_STEPS + 39;

   // Configuration registers
   logic [31:0] phase_step_ff;
   logic [13:0] bin_count_ff;
   logic [13:0] bin_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= gdiv_pkg::PHASE_STEP_RESET;
         bin_count_ff  <= gdiv_pkg::BIN_COUNT_RESET;
      end else if (csr_we) begin
         unique case (gdiv_pkg::csr_index_type'(csr_index))
            gdiv_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            gdiv_pkg::CSR_BIN_COUNT:  bin_count_ff  <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   assign bin_n = (bin_count_ff > 14'(gdiv_pkg::MAX_BINS)) ?
                  14'(gdiv_pkg::MAX_BINS) : bin_count_ff;

   // Request entry
   logic                 accept;
   gdiv_pkg::sample_type in_smp;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      in_smp.meta.valid    = accept;
      in_smp.meta.zero_bin = (req_data.bin_index == '0);
      in_smp.meta.index    = req_data.bin_index;
      in_smp.re            = req_data.spec_re;
      in_smp.im            = req_data.spec_im;
   end

   gdiv_pkg::sample_type ph_smp, co_smp;
   gdiv_pkg::cordic_type ph_cd, co_cd;
   gdiv_pkg::num_type    num;

   gdiv_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .phase_step (phase_step_ff),
      .bin_n      (bin_n),
      .in_smp     (in_smp),
      .out_smp    (ph_smp),
      .out_cd     (ph_cd)
   );

   gdiv_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .in_smp  (ph_smp),
      .in_cd   (ph_cd),
      .out_smp (co_smp),
      .out_cd  (co_cd)
   );

   gdiv_denom u_denom (
      .clock   (clock),
      .reset   (reset),
      .in_smp  (co_smp),
      .in_cd   (co_cd),
      .out_num (num)
   );

   gdiv_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_num    (num),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A result only follows a request that was taken at the pipeline entry
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without matching request");

   // The bin number travels with its data
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_index == $past(req_data.bin_index, LATENCY)))
      else $error("bin index out of step with data");

   // Bin zero always gives a clean zero
   a_bin_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_index == '0) |->
         (rsp_data.out_re == '0 && rsp_data.out_im == '0 && !rsp_data.overflow))
      else $error("bin zero result not zero");
`endif

endmodule

FILE: design/gdiv_phase.sv
module gdiv_phase (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           phase_step,
   input  logic [13:0]           bin_n,
   input  gdiv_pkg::sample_type  in_smp,
   output gdiv_pkg::sample_type  out_smp,
   output gdiv_pkg::cordic_type  out_cd
);

   gdiv_pkg::sample_type a_smp_ff;
   logic [31:0]          pk_ff, pk_in;
   logic [31:0]          pn_ff, pn_in;
   logic                 upper_ff, upper_in;
   logic [44:0]          pk_full;
   logic [45:0]          pn_full;

   // Bin phase and transform-length phase
   assign pk_full  = 45'(in_smp.meta.index) * 45'(phase_step);
   assign pn_full  = 46'(bin_n) * 46'(phase_step);
   assign pk_in    = pk_full[31:0];
   assign pn_in    = pn_full[31:0];
   assign upper_in = {in_smp.meta.index, 1'b0} > bin_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_smp_ff.meta.valid <= 1'b0;
      end else begin
         a_smp_ff <= in_smp;
      end
      pk_ff    <= pk_in;
      pn_ff    <= pn_in;
      upper_ff <= upper_in;
   end

   // Wrap to signed turns and fold into the right half plane
   logic [31:0]                  phase;
   logic signed [gdiv_pkg::CW-1:0] z_raw;
   gdiv_pkg::cordic_type         cd_ff, cd_in;
   gdiv_pkg::sample_type         b_smp_ff;

   assign phase = upper_ff ? (pk_ff - pn_ff) : pk_ff;
   assign z_raw = gdiv_pkg::CW'(signed'(phase));

   always_comb begin
      cd_in.y = '0;
      priority if (z_raw > gdiv_pkg::QUARTER_TURN) begin
         cd_in.z = z_raw - gdiv_pkg::HALF_TURN;
         cd_in.x = -gdiv_pkg::CORDIC_GAIN;
      end else if (z_raw < -gdiv_pkg::QUARTER_TURN) begin
         cd_in.z = z_raw + gdiv_pkg::HALF_TURN;
         cd_in.x = -gdiv_pkg::CORDIC_GAIN;
      end else begin
         cd_in.z = z_raw;
         cd_in.x = gdiv_pkg::CORDIC_GAIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_smp_ff.meta.valid <= 1'b0;
      end else begin
         b_smp_ff <= a_smp_ff;
      end
      cd_ff <= cd_in;
   end

   assign out_smp = b_smp_ff;
   assign out_cd  = cd_ff;

endmodule

FILE: design/gdiv_cordic.sv
module gdiv_cordic #(
   parameter int CORDIC_STEPS = gdiv_pkg::CORDIC_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gdiv_pkg::sample_type  in_smp,
   input  gdiv_pkg::cordic_type  in_cd,
   output gdiv_pkg::sample_type  out_smp,
   output gdiv_pkg::cordic_type  out_cd
);

   gdiv_pkg::sample_type smp_ff [CORDIC_STEPS];
   gdiv_pkg::cordic_type cd_ff  [CORDIC_STEPS];

   // One rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      gdiv_pkg::sample_type           prev_smp;
      gdiv_pkg::cordic_type           prev_cd;
      gdiv_pkg::cordic_type           cd_in;
      logic signed [gdiv_pkg::CW-1:0] xs, ys, zs, dx, dy, ang;

      if (i == 0) begin : g_first
         assign prev_smp = in_smp;
         assign prev_cd  = in_cd;
      end else begin : g_next
         assign prev_smp = smp_ff[i-1];
         assign prev_cd  = cd_ff[i-1];
      end

      assign xs  = prev_cd.x;
      assign ys  = prev_cd.y;
      assign zs  = prev_cd.z;
      assign dx  = ys >>> i;
      assign dy  = xs >>> i;
      assign ang = signed'({2'b00, gdiv_pkg::ATAN_TURNS[i % 32]});

      always_comb begin
         if (zs >= 0) begin
            cd_in.x = xs - dx;
            cd_in.y = ys + dy;
            cd_in.z = zs - ang;
         end else begin
            cd_in.x = xs + dx;
            cd_in.y = ys - dy;
            cd_in.z = zs + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            smp_ff[i].meta.valid <= 1'b0;
         end else begin
            smp_ff[i] <= prev_smp;
         end
         cd_ff[i] <= cd_in;
      end
   end

   assign out_smp = smp_ff[CORDIC_STEPS-1];
   assign out_cd  = cd_ff[CORDIC_STEPS-1];

endmodule

FILE: design/gdiv_denom.sv
module gdiv_denom (
   input  logic                  clock,
   input  logic                  reset,
   input  gdiv_pkg::sample_type  in_smp,
   input  gdiv_pkg::cordic_type  in_cd,
   output gdiv_pkg::num_type     out_num
);

   // Ghost operator in Q28
   logic signed [gdiv_pkg::CW-1:0] dr_wide, di_wide;
   logic signed [31:0]             dr_ff, di_ff;
   gdiv_pkg::sample_type           d_smp_ff;

   assign dr_wide = (gdiv_pkg::ONE_Q30 - in_cd.x) >>> 2;
   assign di_wide = in_cd.y >>> 2;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_smp_ff.meta.valid <= 1'b0;
      end else begin
         d_smp_ff <= in_smp;
      end
      dr_ff <= dr_wide[31:0];
      di_ff <= di_wide[31:0];
   end

   // Cross products and squared magnitude terms
   logic signed [63:0] p_rr_ff, p_id_ff, p_ir_ff, p_rd_ff, p_dd_ff, p_ii_ff;
   gdiv_pkg::meta_type p_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_meta_ff.valid <= 1'b0;
      end else begin
         p_meta_ff <= d_smp_ff.meta;
      end
      p_rr_ff <= d_smp_ff.re * dr_ff;
      p_id_ff <= d_smp_ff.im * di_ff;
      p_ir_ff <= d_smp_ff.im * dr_ff;
      p_rd_ff <= d_smp_ff.re * di_ff;
      p_dd_ff <= dr_ff * dr_ff;
      p_ii_ff <= di_ff * di_ff;
   end

   // Numerators and scaled denominator
   logic signed [63:0]   msum;
   gdiv_pkg::num_type    num_ff, num_in;

   assign msum = p_dd_ff + p_ii_ff;

   always_comb begin
      num_in.meta = p_meta_ff;
      num_in.nre  = p_rr_ff + p_id_ff;
      num_in.nim  = p_ir_ff - p_rd_ff;
      num_in.m    = msum[gdiv_pkg::MW+11:12];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff.meta.valid <= 1'b0;
      end else begin
         num_ff <= num_in;
      end
   end

   assign out_num = num_ff;

endmodule

FILE: design/gdiv_divider.sv
module gdiv_divider (
   input  logic                clock,
   input  logic                reset,
   input  gdiv_pkg::num_type   in_num,
   output logic                rsp_valid,
   output gdiv_pkg::rsp_type   rsp_data
);

   localparam int STEPS = gdiv_pkg::QW;

   // Set up one lane: magnitude, sign and early saturation
   function automatic gdiv_pkg::div_lane_type lane_init(logic signed [63:0] n,
                                                        logic [gdiv_pkg::MW-1:0] m);
      gdiv_pkg::div_lane_type l;
      logic [63:0]            mag;
      mag   = n[63] ? 64'(-n) : 64'(n);
      l.rem = gdiv_pkg::MW'(mag[63:32]);
      l.low = mag[31:0];
      l.q   = '0;
      l.neg = n[63];
      l.nz  = (n != 64'sd0);
      l.big = gdiv_pkg::MW'(mag[63:32]) >= m;
      return l;
   endfunction

   // One restoring division bit
   function automatic gdiv_pkg::div_lane_type lane_step(gdiv_pkg::div_lane_type l,
                                                        logic [gdiv_pkg::MW-1:0] m);
      gdiv_pkg::div_lane_type r;
      logic [gdiv_pkg::MW:0]  sh;
      logic [gdiv_pkg::MW:0]  diff;
      logic                   ge;
      sh    = {l.rem, l.low[31]};
      diff  = sh - {1'b0, m};
      ge    = sh >= {1'b0, m};
      r     = l;
      r.rem = ge ? diff[gdiv_pkg::MW-1:0] : sh[gdiv_pkg::MW-1:0];
      r.low = {l.low[30:0], 1'b0};
      r.q   = {l.q[gdiv_pkg::QW-2:0], ge};
      return r;
   endfunction

   gdiv_pkg::div_stage_type s0_ff, s0_in;

   always_comb begin
      s0_in.meta   = in_num.meta;
      s0_in.m      = in_num.m;
      s0_in.zero_m = (in_num.m == '0);
      s0_in.lre    = lane_init(in_num.nre, in_num.m);
      s0_in.lim    = lane_init(in_num.nim, in_num.m);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.meta.valid <= 1'b0;
      end else begin
         s0_ff <= s0_in;
      end
   end

   // Quotient bits, one stage each
   gdiv_pkg::div_stage_type st_ff [STEPS];

   for (genvar j = 0; j < STEPS; j++) begin : g_bit
      gdiv_pkg::div_stage_type prev, nxt;

      if (j == 0) begin : g_first
         assign prev = s0_ff;
      end else begin : g_next
         assign prev = st_ff[j-1];
      end

      always_comb begin
         nxt     = prev;
         nxt.lre = lane_step(prev.lre, prev.m);
         nxt.lim = lane_step(prev.lim, prev.m);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[j].meta.valid <= 1'b0;
         end else begin
            st_ff[j] <= nxt;
         end
      end
   end

   // Sign, clamp and bin-zero override
   function automatic logic [32:0] lane_out(gdiv_pkg::div_lane_type l);
      logic        sat;
      logic [31:0] val;
      sat = 1'b0;
      val = '0;
      priority if (!l.nz) begin
         val = '0;
      end else if (l.big) begin
         sat = 1'b1;
      end else if (l.neg) begin
         if (l.q > 32'h8000_0000) sat = 1'b1;
         else val = -l.q;
      end else begin
         if (l.q > 32'h7FFF_FFFF) sat = 1'b1;
         else val = l.q;
      end
      if (sat) val = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return {sat, val};
   endfunction

   gdiv_pkg::div_stage_type last;
   logic [32:0]             ore, oim;
   logic                    rsp_valid_ff, rsp_valid_in;
   gdiv_pkg::rsp_type       rsp_ff, rsp_in;

   assign last         = st_ff[STEPS-1];
   assign ore          = lane_out(last.lre);
   assign oim          = lane_out(last.lim);
   assign rsp_valid_in = last.meta.valid;

   always_comb begin
      rsp_in.out_index = last.meta.index;
      if (last.meta.zero_bin) begin
         rsp_in.out_re   = '0;
         rsp_in.out_im   = '0;
         rsp_in.overflow = 1'b0;
      end else begin
         rsp_in.out_re   = ore[31:0];
         rsp_in.out_im   = oim[31:0];
         rsp_in.overflow = last.zero_m | ore[32] | oim[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
